// ===== design/plob_pkg.sv =====
`timescale 1ns / 1ps

package plob_pkg;

  localparam int LEVELS_DEF      = 64;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int MAX_REPORT_DEF  = 16;

  localparam int MODE_W   = 2;
  localparam int PRICE_W  = 32;
  localparam int QTY_W    = 32;
  localparam int TOP_W    = 5;
  localparam int STATUS_W = 2;
  localparam int TOTAL_W  = 36;
  localparam int COUNT_W  = 5;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD    = 2'd0,
    MODE_CANCEL = 2'd1,
    MODE_MODIFY = 2'd2,
    MODE_QUERY  = 2'd3
  } mode_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK         = 2'd0,
    STATUS_NOT_FOUND  = 2'd1,
    STATUS_TABLE_FULL = 2'd2,
    STATUS_QUEUE_FULL = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    ST_INIT,
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_DISPATCH,
    ST_ADD_META,
    ST_INS_FREE_RD,
    ST_INS_FREE,
    ST_SHUP_RD,
    ST_SHUP_WR,
    ST_INS_WR,
    ST_CAN_META,
    ST_CAN_RD,
    ST_CAN_ACC,
    ST_CAN_END,
    ST_SHDN_RD,
    ST_SHDN_WR,
    ST_DEL_WR,
    ST_Q_START,
    ST_Q_RD,
    ST_Q_PTR,
    ST_Q_META,
    ST_Q_LD,
    ST_SUM_INIT,
    ST_SUM_RD,
    ST_SUM_ACC,
    ST_EMIT,
    ST_OUT
  } state_t;

endpackage

// ===== design/plob_if.sv =====
`timescale 1ns / 1ps

interface plob_in_if;
  logic                         valid;
  logic                         ready;
  logic [plob_pkg::MODE_W-1:0]  mode;
  logic                         side;
  logic [plob_pkg::PRICE_W-1:0] price;
  logic [plob_pkg::QTY_W-1:0]   quantity;
  logic [plob_pkg::TOP_W-1:0]   top_count;

  modport source (output valid, mode, side, price, quantity, top_count, input ready);
  modport sink (input valid, mode, side, price, quantity, top_count, output ready);
endinterface

interface plob_out_if;
  logic                          valid;
  logic                          ready;
  logic [plob_pkg::STATUS_W-1:0] status;
  logic [plob_pkg::PRICE_W-1:0]  level_price;
  logic [plob_pkg::TOTAL_W-1:0]  total_quantity;
  logic [plob_pkg::COUNT_W-1:0]  entry_count;
  logic                          last;

  modport source (output valid, status, level_price, total_quantity, entry_count, last,
                  input ready);
  modport sink (input valid, status, level_price, total_quantity, entry_count, last,
                output ready);
endinterface

// ===== design/price_level_order_book_top.sv =====
`timescale 1ns / 1ps

// Two-sided price-level order book with a valid/ready request channel in_chan and a
// valid/ready result channel out_chan. Each request carries mode, side, price, quantity
// and top_count; add, cancel and modify give one result, a query gives one result per
// reported level with last set on the final one.
// One request is handled at a time, under a single sequencer that owns one read and
// one write port on each of three memories (sorted level table, per-level queue state,
// queue entries). The work of a request grows with the levels passed in the price
// search, the levels moved when a level is inserted or deleted, the queue entries
// consumed by a cancel and the entries summed for a reported total.
// After reset the block makes a clearing pass that seeds the level table with free
// slots, with in_chan.ready low; the book then starts empty.
// A result waits in an output register until out_chan.ready is high; the block takes
// no new request until all results of the current one have been taken.
module price_level_order_book_top #(
  parameter int LEVELS      = plob_pkg::LEVELS_DEF,
  parameter int QUEUE_DEPTH = plob_pkg::QUEUE_DEPTH_DEF,
  parameter int MAX_REPORT  = plob_pkg::MAX_REPORT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  plob_in_if.sink     in_chan,
  plob_out_if.source  out_chan
);

  localparam int LW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int SW    = $clog2(2 * LEVELS);
  localparam int CW    = $clog2(LEVELS + 1);
  localparam int QW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int LENW  = $clog2(QUEUE_DEPTH + 1);
  localparam int QAW   = $clog2(2 * LEVELS * QUEUE_DEPTH);
  localparam int OW    = plob_pkg::PRICE_W + LW;
  localparam int MW    = QW + LENW;
  localparam int PW    = plob_pkg::PRICE_W;
  localparam int TW    = plob_pkg::TOTAL_W;

  // Memories
  logic [OW-1:0]  ord_mem [2*LEVELS];
  logic [MW-1:0]  meta_mem [2*LEVELS];
  logic [PW-1:0]  q_mem [2*LEVELS*QUEUE_DEPTH];

  logic           ord_we, meta_we, q_we;
  logic [SW-1:0]  ord_waddr, ord_raddr;
  logic [OW-1:0]  ord_wdata, ord_rdata_r;
  logic [MW-1:0]  meta_wdata, meta_rdata_r;
  logic [QAW-1:0] q_waddr, q_raddr;
  logic [PW-1:0]  q_wdata, q_rdata_r;

  plob_pkg::state_t state_r, state_nxt;

  logic [SW-1:0]   init_r, init_nxt;
  logic [CW-1:0]   cnt_r [2];
  logic [CW-1:0]   cnt_nxt [2];
  logic [1:0]      mode_r, mode_nxt;
  logic            side_r, side_nxt;
  logic [PW-1:0]   price_r, price_nxt;
  logic [PW-1:0]   qty_r, qty_nxt;
  logic [4:0]      top_r, top_nxt;
  logic [CW-1:0]   n_r, n_nxt;
  logic [CW-1:0]   pos_r, pos_nxt;
  logic            found_r, found_nxt;
  logic [LW-1:0]   ptr_r, ptr_nxt;
  logic [SW-1:0]   slot_r, slot_nxt;
  logic [QW-1:0]   head_r, head_nxt;
  logic [LENW-1:0] len_r, len_nxt;
  logic [QW-1:0]   idx_r, idx_nxt;
  logic [LENW-1:0] k_r, k_nxt;
  logic [TW-1:0]   sum_r, sum_nxt;
  logic [PW-1:0]   rem_r, rem_nxt;
  logic [CW-1:0]   i_r, i_nxt;
  logic [CW-1:0]   tq_r, tq_nxt;
  logic [CW-1:0]   kq_r, kq_nxt;
  logic [PW-1:0]   key_r, key_nxt;
  logic [1:0]      status_r, status_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic [1:0]      out_status_r, out_status_nxt;
  logic [PW-1:0]   out_price_r, out_price_nxt;
  logic [TW-1:0]   out_total_r, out_total_nxt;
  logic [4:0]      out_count_r, out_count_nxt;
  logic            out_last_r, out_last_nxt;

  logic [PW-1:0]   okey;
  logic [LW-1:0]   optr;
  logic [QW-1:0]   mhead;
  logic [LENW-1:0] mlen;
  logic            in_acc, out_acc, last_res;
  logic [QW-1:0]   tail_idx;
  logic [LENW:0]   tail_sum;
  logic [TW:0]     sum_ext;
  logic [31:0]     tcap;

  function automatic logic [SW-1:0] ord_addr(input logic side, input logic [CW-1:0] p);
    ord_addr = side ? SW'(LEVELS) + SW'(p) : SW'(p);
  endfunction

  function automatic logic [SW-1:0] phys_slot(input logic side, input logic [LW-1:0] p);
    phys_slot = side ? SW'(LEVELS) + SW'(p) : SW'(p);
  endfunction

  function automatic logic [QAW-1:0] q_addr(input logic [SW-1:0] s, input logic [QW-1:0] ix);
    q_addr = QAW'(s) * QAW'(QUEUE_DEPTH) + QAW'(ix);
  endfunction

  function automatic logic [QW-1:0] wrap_inc(input logic [QW-1:0] ix);
    wrap_inc = (32'(ix) == QUEUE_DEPTH - 1) ? '0 : ix + QW'(1);
  endfunction

  assign okey  = ord_rdata_r[OW-1:LW];
  assign optr  = ord_rdata_r[LW-1:0];
  assign mhead = meta_rdata_r[MW-1:LENW];
  assign mlen  = meta_rdata_r[LENW-1:0];

  assign in_acc  = in_chan.valid && in_chan.ready;
  assign out_acc = out_valid_r && out_chan.ready;

  assign last_res = (mode_r != plob_pkg::MODE_QUERY) || (status_r != plob_pkg::STATUS_OK)
                    || (kq_r + CW'(1) == tq_r);

  assign tail_sum = (LENW+1)'(mhead) + (LENW+1)'(mlen);
  assign tail_idx = (32'(tail_sum) >= QUEUE_DEPTH) ? QW'(tail_sum - (LENW+1)'(QUEUE_DEPTH))
                                                   : QW'(tail_sum);
  assign sum_ext  = {1'b0, sum_r} + (TW+1)'(q_rdata_r);

  assign in_chan.ready           = (state_r == plob_pkg::ST_IDLE);
  assign out_chan.valid          = out_valid_r;
  assign out_chan.status         = out_status_r;
  assign out_chan.level_price    = out_price_r;
  assign out_chan.total_quantity = out_total_r;
  assign out_chan.entry_count    = out_count_r;
  assign out_chan.last           = out_last_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      plob_pkg::ST_INIT: begin
        if (32'(init_r) == 2 * LEVELS - 1) state_nxt = plob_pkg::ST_IDLE;
      end
      plob_pkg::ST_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_chan.mode == plob_pkg::MODE_QUERY) ? plob_pkg::ST_Q_START
                                                             : plob_pkg::ST_SRCH_RD;
        end
      end
      plob_pkg::ST_SRCH_RD:
        state_nxt = (pos_r == n_r) ? plob_pkg::ST_DISPATCH : plob_pkg::ST_SRCH_CMP;
      plob_pkg::ST_SRCH_CMP:
        state_nxt = (okey < price_r) ? plob_pkg::ST_SRCH_RD : plob_pkg::ST_DISPATCH;
      plob_pkg::ST_DISPATCH: begin
        case (mode_r)
          plob_pkg::MODE_ADD: begin
            if (found_r) state_nxt = plob_pkg::ST_ADD_META;
            else if (32'(n_r) >= LEVELS) state_nxt = plob_pkg::ST_EMIT;
            else state_nxt = plob_pkg::ST_INS_FREE_RD;
          end
          plob_pkg::MODE_CANCEL:
            state_nxt = found_r ? plob_pkg::ST_CAN_META : plob_pkg::ST_EMIT;
          default:
            state_nxt = found_r ? plob_pkg::ST_SUM_INIT : plob_pkg::ST_EMIT;
        endcase
      end
      plob_pkg::ST_ADD_META:    state_nxt = plob_pkg::ST_SUM_INIT;
      plob_pkg::ST_INS_FREE_RD: state_nxt = plob_pkg::ST_INS_FREE;
      plob_pkg::ST_INS_FREE:    state_nxt = plob_pkg::ST_SHUP_RD;
      plob_pkg::ST_SHUP_RD:
        state_nxt = (i_r == pos_r) ? plob_pkg::ST_INS_WR : plob_pkg::ST_SHUP_WR;
      plob_pkg::ST_SHUP_WR:     state_nxt = plob_pkg::ST_SHUP_RD;
      plob_pkg::ST_INS_WR:      state_nxt = plob_pkg::ST_SUM_INIT;
      plob_pkg::ST_CAN_META:    state_nxt = plob_pkg::ST_CAN_RD;
      plob_pkg::ST_CAN_RD: begin
        state_nxt = (rem_r == '0 || len_r == '0) ? plob_pkg::ST_CAN_END
                                                 : plob_pkg::ST_CAN_ACC;
      end
      plob_pkg::ST_CAN_ACC:     state_nxt = plob_pkg::ST_CAN_RD;
      plob_pkg::ST_CAN_END:
        state_nxt = (len_r == '0) ? plob_pkg::ST_SHDN_RD : plob_pkg::ST_SUM_INIT;
      plob_pkg::ST_SHDN_RD:
        state_nxt = (i_r + CW'(1) == n_r) ? plob_pkg::ST_DEL_WR : plob_pkg::ST_SHDN_WR;
      plob_pkg::ST_SHDN_WR:     state_nxt = plob_pkg::ST_SHDN_RD;
      plob_pkg::ST_DEL_WR:      state_nxt = plob_pkg::ST_EMIT;
      plob_pkg::ST_Q_START:
        state_nxt = (n_r == '0) ? plob_pkg::ST_EMIT : plob_pkg::ST_Q_RD;
      plob_pkg::ST_Q_RD:        state_nxt = plob_pkg::ST_Q_PTR;
      plob_pkg::ST_Q_PTR:       state_nxt = plob_pkg::ST_Q_META;
      plob_pkg::ST_Q_META:      state_nxt = plob_pkg::ST_Q_LD;
      plob_pkg::ST_Q_LD:        state_nxt = plob_pkg::ST_SUM_INIT;
      plob_pkg::ST_SUM_INIT:    state_nxt = plob_pkg::ST_SUM_RD;
      plob_pkg::ST_SUM_RD:
        state_nxt = (k_r == len_r) ? plob_pkg::ST_EMIT : plob_pkg::ST_SUM_ACC;
      plob_pkg::ST_SUM_ACC:     state_nxt = plob_pkg::ST_SUM_RD;
      plob_pkg::ST_EMIT:        state_nxt = plob_pkg::ST_OUT;
      plob_pkg::ST_OUT: begin
        if (out_acc) state_nxt = out_last_r ? plob_pkg::ST_IDLE : plob_pkg::ST_Q_RD;
      end
      default:                  state_nxt = plob_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    tcap        = '0;
    init_nxt    = init_r;
    cnt_nxt[0]  = cnt_r[0];
    cnt_nxt[1]  = cnt_r[1];
    mode_nxt    = mode_r;
    side_nxt    = side_r;
    price_nxt   = price_r;
    qty_nxt     = qty_r;
    top_nxt     = top_r;
    n_nxt       = n_r;
    pos_nxt     = pos_r;
    found_nxt   = found_r;
    ptr_nxt     = ptr_r;
    slot_nxt    = slot_r;
    head_nxt    = head_r;
    len_nxt     = len_r;
    idx_nxt     = idx_r;
    k_nxt       = k_r;
    sum_nxt     = sum_r;
    rem_nxt     = rem_r;
    i_nxt       = i_r;
    tq_nxt      = tq_r;
    kq_nxt      = kq_r;
    key_nxt     = key_r;
    status_nxt  = status_r;

    out_valid_nxt  = out_valid_r;
    out_status_nxt = out_status_r;
    out_price_nxt  = out_price_r;
    out_total_nxt  = out_total_r;
    out_count_nxt  = out_count_r;
    out_last_nxt   = out_last_r;

    ord_we     = 1'b0;
    ord_waddr  = ord_addr(side_r, i_r);
    ord_wdata  = ord_rdata_r;
    ord_raddr  = ord_addr(side_r, pos_r);
    meta_we    = 1'b0;
    meta_wdata = {head_r, len_r};
    q_we       = 1'b0;
    q_waddr    = q_addr(slot_r, head_r);
    q_wdata    = qty_r;
    q_raddr    = q_addr(slot_r, idx_r);

    case (state_r)
      plob_pkg::ST_INIT: begin
        ord_we    = 1'b1;
        ord_waddr = init_r;
        ord_wdata = {PW'(0), (32'(init_r) < LEVELS) ? LW'(init_r)
                                                    : LW'(init_r - SW'(LEVELS))};
        init_nxt  = init_r + SW'(1);
      end
      plob_pkg::ST_IDLE: begin
        if (in_acc) begin
          mode_nxt   = in_chan.mode;
          side_nxt   = in_chan.side;
          price_nxt  = in_chan.price;
          qty_nxt    = in_chan.quantity;
          top_nxt    = in_chan.top_count;
          n_nxt      = cnt_r[in_chan.side];
          pos_nxt    = '0;
          found_nxt  = 1'b0;
          key_nxt    = in_chan.price;
          kq_nxt     = '0;
          sum_nxt    = '0;
          len_nxt    = '0;
          status_nxt = plob_pkg::STATUS_OK;
        end
      end
      plob_pkg::ST_SRCH_CMP: begin
        if (okey < price_r) begin
          pos_nxt = pos_r + CW'(1);
        end else begin
          found_nxt = (okey == price_r);
          ptr_nxt   = optr;
          slot_nxt  = phys_slot(side_r, optr);
        end
      end
      plob_pkg::ST_DISPATCH: begin
        if (!found_r) begin
          if (mode_r == plob_pkg::MODE_ADD) begin
            if (32'(n_r) >= LEVELS) status_nxt = plob_pkg::STATUS_TABLE_FULL;
          end else begin
            status_nxt = plob_pkg::STATUS_NOT_FOUND;
          end
          i_nxt = n_r;
        end else if (mode_r == plob_pkg::MODE_MODIFY) begin
          // Modify collapses the level to a single entry at queue position zero.
          meta_we    = 1'b1;
          meta_wdata = {QW'(0), LENW'(1)};
          q_we       = 1'b1;
          q_waddr    = q_addr(slot_r, '0);
          head_nxt   = '0;
          len_nxt    = LENW'(1);
        end
      end
      plob_pkg::ST_ADD_META: begin
        head_nxt = mhead;
        len_nxt  = mlen;
        if (32'(mlen) >= QUEUE_DEPTH) begin
          status_nxt = plob_pkg::STATUS_QUEUE_FULL;
        end else begin
          q_we       = 1'b1;
          q_waddr    = q_addr(slot_r, tail_idx);
          meta_we    = 1'b1;
          meta_wdata = {mhead, mlen + LENW'(1)};
          len_nxt    = mlen + LENW'(1);
        end
      end
      plob_pkg::ST_INS_FREE_RD: begin
        ord_raddr = ord_addr(side_r, n_r);
      end
      plob_pkg::ST_INS_FREE: begin
        // The entry just past the live levels always names a free slot.
        ptr_nxt  = optr;
        slot_nxt = phys_slot(side_r, optr);
      end
      plob_pkg::ST_SHUP_RD: begin
        ord_raddr = ord_addr(side_r, i_r - CW'(1));
      end
      plob_pkg::ST_SHUP_WR: begin
        ord_we    = 1'b1;
        ord_waddr = ord_addr(side_r, i_r);
        i_nxt     = i_r - CW'(1);
      end
      plob_pkg::ST_INS_WR: begin
        ord_we           = 1'b1;
        ord_waddr        = ord_addr(side_r, pos_r);
        ord_wdata        = {price_r, ptr_r};
        meta_we          = 1'b1;
        meta_wdata       = {QW'(0), LENW'(1)};
        q_we             = 1'b1;
        q_waddr          = q_addr(slot_r, '0);
        cnt_nxt[side_r]  = cnt_r[side_r] + CW'(1);
        head_nxt         = '0;
        len_nxt          = LENW'(1);
      end
      plob_pkg::ST_CAN_META: begin
        head_nxt = mhead;
        len_nxt  = mlen;
        rem_nxt  = qty_r;
      end
      plob_pkg::ST_CAN_RD: begin
        q_raddr = q_addr(slot_r, head_r);
      end
      plob_pkg::ST_CAN_ACC: begin
        if (q_rdata_r <= rem_r) begin
          rem_nxt  = rem_r - q_rdata_r;
          head_nxt = wrap_inc(head_r);
          len_nxt  = len_r - LENW'(1);
        end else begin
          // The front entry is only partly consumed, so it is trimmed in place.
          q_we    = 1'b1;
          q_waddr = q_addr(slot_r, head_r);
          q_wdata = q_rdata_r - rem_r;
          rem_nxt = '0;
        end
      end
      plob_pkg::ST_CAN_END: begin
        meta_we    = 1'b1;
        meta_wdata = {head_r, len_r};
        i_nxt      = pos_r;
      end
      plob_pkg::ST_SHDN_RD: begin
        ord_raddr = ord_addr(side_r, i_r + CW'(1));
      end
      plob_pkg::ST_SHDN_WR: begin
        ord_we    = 1'b1;
        ord_waddr = ord_addr(side_r, i_r);
        i_nxt     = i_r + CW'(1);
      end
      plob_pkg::ST_DEL_WR: begin
        // The freed slot goes back just past the remaining live levels.
        ord_we          = 1'b1;
        ord_waddr       = ord_addr(side_r, n_r - CW'(1));
        ord_wdata       = {price_r, ptr_r};
        cnt_nxt[side_r] = cnt_r[side_r] - CW'(1);
        sum_nxt         = '0;
        len_nxt         = '0;
      end
      plob_pkg::ST_Q_START: begin
        if (n_r == '0) begin
          status_nxt = plob_pkg::STATUS_NOT_FOUND;
        end else begin
          tcap = (top_r == '0) ? 32'd1 : 32'(top_r);
          if (tcap > 32'(MAX_REPORT)) tcap = 32'(MAX_REPORT);
          if (tcap > 32'(n_r)) tcap = 32'(n_r);
          tq_nxt = CW'(tcap);
        end
      end
      plob_pkg::ST_Q_RD: begin
        ord_raddr = ord_addr(side_r, kq_r);
      end
      plob_pkg::ST_Q_PTR: begin
        key_nxt  = okey;
        slot_nxt = phys_slot(side_r, optr);
      end
      plob_pkg::ST_Q_LD: begin
        head_nxt = mhead;
        len_nxt  = mlen;
      end
      plob_pkg::ST_SUM_INIT: begin
        idx_nxt = head_r;
        k_nxt   = '0;
        sum_nxt = '0;
      end
      plob_pkg::ST_SUM_ACC: begin
        sum_nxt = sum_ext[TW] ? '1 : sum_ext[TW-1:0];
        idx_nxt = wrap_inc(idx_r);
        k_nxt   = k_r + LENW'(1);
      end
      plob_pkg::ST_EMIT: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = status_r;
        out_price_nxt  = key_r;
        out_total_nxt  = sum_r;
        out_count_nxt  = 5'(len_r);
        out_last_nxt   = last_res;
      end
      plob_pkg::ST_OUT: begin
        if (out_acc) begin
          out_valid_nxt = 1'b0;
          kq_nxt        = kq_r + CW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= plob_pkg::ST_INIT;
      init_r      <= '0;
      cnt_r[0]    <= '0;
      cnt_r[1]    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      init_r      <= init_nxt;
      cnt_r[0]    <= cnt_nxt[0];
      cnt_r[1]    <= cnt_nxt[1];
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r       <= mode_nxt;
    side_r       <= side_nxt;
    price_r      <= price_nxt;
    qty_r        <= qty_nxt;
    top_r        <= top_nxt;
    n_r          <= n_nxt;
    pos_r        <= pos_nxt;
    found_r      <= found_nxt;
    ptr_r        <= ptr_nxt;
    slot_r       <= slot_nxt;
    head_r       <= head_nxt;
    len_r        <= len_nxt;
    idx_r        <= idx_nxt;
    k_r          <= k_nxt;
    sum_r        <= sum_nxt;
    rem_r        <= rem_nxt;
    i_r          <= i_nxt;
    tq_r         <= tq_nxt;
    kq_r         <= kq_nxt;
    key_r        <= key_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_price_r  <= out_price_nxt;
    out_total_r  <= out_total_nxt;
    out_count_r  <= out_count_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (ord_we) ord_mem[ord_waddr] <= ord_wdata;
    ord_rdata_r <= ord_mem[ord_raddr];
  end

  always_ff @(posedge clk) begin
    if (meta_we) meta_mem[slot_r] <= meta_wdata;
    meta_rdata_r <= meta_mem[slot_r];
  end

  always_ff @(posedge clk) begin
    if (q_we) q_mem[q_waddr] <= q_wdata;
    q_rdata_r <= q_mem[q_raddr];
  end

endmodule
